// ===== hw/rtl/gld_pkg.sv =====
// Package for the GIF LZW decoder: payload structs, status and mode codes,
// controller/datapath command and status structs. No dependencies.
package gld_pkg;
	localparam int TableSize = 4096;
	localparam int PixelCountBits = 24;
	localparam int StackDepth = TableSize + 1;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE = 2'd1;
	localparam logic [1:0] MODE_PIXEL = 2'd2;

	localparam logic [3:0] ST_PIXEL = 4'd0;
	localparam logic [3:0] ST_NEED = 4'd1;
	localparam logic [3:0] ST_TAKEN = 4'd2;
	localparam logic [3:0] ST_REFUSED = 4'd3;
	localparam logic [3:0] ST_DONE = 4'd4;
	localparam logic [3:0] ST_ENDCODE = 4'd5;
	localparam logic [3:0] ST_BAD = 4'd6;
	localparam logic [3:0] ST_FULL = 4'd7;
	localparam logic [3:0] ST_EXHAUSTED = 4'd8;
	localparam logic [3:0] ST_STARTED = 4'd9;

	localparam logic CFG_MIN_CODE_SIZE = 1'b0;
	localparam logic CFG_FRAME_PIXELS = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0] status;
		logic [7:0] pixel_index;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic init;         // start frame: registers and table fill
		logic fill_step;    // write root entry at fill counter
		logic take_byte;    // append input byte
		logic set_end;      // latch end state
		logic [3:0] end_code;
		logic read_code;    // extract code from bit buffer and classify
		logic restart;      // clear code handling
		logic first_code;   // first code after clear
		logic kwkwk;        // code equals next free code
		logic walk_push;    // push suffix read, follow prefix
		logic add_entry;    // push first char and add table entry
		logic pop;          // count popped pixel
		logic clear_stack;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fill_done;
		logic byte_ok;
		logic bits_short;
		logic input_done;
		logic [3:0] end_state;
		logic frame_done;
		logic stack_empty;
		logic is_end_code;
		logic is_bad;
		logic is_clear;
		logic prev_valid;
		logic first_bad;
		logic is_next;
		logic walk_more;
		logic table_full;
		logic [7:0] pixel;
	} dp_stat_t;
endpackage

// ===== hw/rtl/gif_lzw_decoder_top.sv =====
// Top level of the GIF LZW decoder: configuration registers, controller and
// datapath. Uses gld_pkg, gld_control and gld_datapath.
// A byte or start transfer is answered in the cycle after it is taken. After reset
// and after each start a root table load runs during which no item is taken. A pixel
// from a filled stack is read in S_POPRD and given in S_POP; a first code after a
// start or clear passes S_CODE, S_READ and S_CLASS; any other new code also walks the
// prefix chain through the table RAM in S_WRD and S_WALK. A clear code re-enters S_CODE.
module gif_lzw_decoder_top #(
	parameter int PixelCountBits = gld_pkg::PixelCountBits
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [PixelCountBits-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input gld_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output gld_pkg::out_item_t out_item
);
	import gld_pkg::*;

	logic [3:0] min_size_q;
	logic [PixelCountBits-1:0] frame_pixels_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q <= 4'd8;
			frame_pixels_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_CODE_SIZE: min_size_q <= cfg_data[3:0];
				CFG_FRAME_PIXELS: frame_pixels_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gld_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_item), .cmd(cmd), .stat(stat));

	gld_datapath #(.PixelCountBits(PixelCountBits)) u_dp (
		.clk(clk), .arst_n(arst_n), .min_code_size(min_size_q),
		.frame_pixels(frame_pixels_q), .item(in_item), .cmd(cmd), .stat(stat));
endmodule

// ===== hw/rtl/gld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gld_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/gld_datapath.sv =====
// Datapath of the GIF LZW decoder: bit buffer, code registers, prefix/suffix
// tables, string stack and pixel counter. Uses gld_pkg and gld_ram.
module gld_datapath #(
	parameter int PixelCountBits = gld_pkg::PixelCountBits
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0] min_code_size,
	input logic [PixelCountBits-1:0] frame_pixels,
	input gld_pkg::in_item_t item,
	input gld_pkg::dp_cmd_t cmd,
	output gld_pkg::dp_stat_t stat
);
	import gld_pkg::*;

	localparam int AW = $clog2(TableSize);
	localparam int SW = $clog2(StackDepth);

	logic [31:0] buf_q;
	logic [5:0] cnt_q;
	logic [3:0] width_q;
	logic [11:0] mask_q;
	logic [12:0] next_q;
	logic [11:0] prev_q;
	logic prev_valid_q;
	logic [7:0] first_q;
	logic [3:0] root_q;
	logic [PixelCountBits-1:0] given_q;
	logic [3:0] end_q;
	logic fin_q;
	logic [SW-1:0] sp_q;
	logic [11:0] code_q;
	logic [11:0] in_code_q;
	logic [12:0] fill_q;
	logic [12:0] walk_q;

	logic [3:0] root_c;
	logic [12:0] clear_c;
	logic [11:0] code_c;
	logic [AW-1:0] rd_addr;
	logic [11:0] pre_rd;
	logic [7:0] suf_rd;
	logic [7:0] stk_rd;
	logic pre_we, suf_we, stk_we;
	logic [AW-1:0] tw_addr;
	logic [11:0] pre_wd;
	logic [7:0] suf_wd;
	logic [SW-1:0] stk_wa, stk_ra;
	logic [7:0] stk_wd;
	logic [7:0] first_c;
	logic [12:0] next_inc;

	assign root_c = (min_code_size < 4'd2) ? 4'd2 :
		((min_code_size > 4'd8) ? 4'd8 : min_code_size);
	assign clear_c = 13'd1 << root_q;
	assign code_c = buf_q[11:0] & mask_q;

	gld_ram #(.Width(12), .Depth(TableSize)) u_prefix (
		.clk(clk), .we(pre_we), .waddr(tw_addr), .wdata(pre_wd),
		.raddr(rd_addr), .rdata(pre_rd));
	gld_ram #(.Width(8), .Depth(TableSize)) u_suffix (
		.clk(clk), .we(suf_we), .waddr(tw_addr), .wdata(suf_wd),
		.raddr(rd_addr), .rdata(suf_rd));
	gld_ram #(.Width(8), .Depth(StackDepth)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd));

	assign first_c = suf_rd;
	assign next_inc = next_q + 13'd1;

	always_comb begin
		pre_we = 1'b0;
		suf_we = 1'b0;
		tw_addr = fill_q[AW-1:0];
		pre_wd = '0;
		suf_wd = fill_q[7:0];
		if (cmd.fill_step) begin
			pre_we = 1'b1;
			suf_we = 1'b1;
			suf_wd = (fill_q < (13'd1 << root_q)) ? fill_q[7:0] : 8'd0;
		end else if (cmd.add_entry && next_q < 13'(TableSize)) begin
			pre_we = 1'b1;
			suf_we = 1'b1;
			tw_addr = next_q[AW-1:0];
			pre_wd = prev_q;
			suf_wd = first_c;
		end
		rd_addr = walk_q[AW-1:0];
		if (cmd.read_code) begin
			rd_addr = code_c[AW-1:0];
		end
		stk_we = 1'b0;
		stk_wa = sp_q;
		stk_wd = suf_rd;
		if (cmd.kwkwk) begin
			stk_we = 1'b1;
			stk_wd = first_q;
		end else if (cmd.walk_push || cmd.first_code) begin
			stk_we = 1'b1;
		end else if (cmd.add_entry && next_q < 13'(TableSize)) begin
			stk_we = 1'b1;
			stk_wd = first_c;
		end
		if (sp_q == SW'(StackDepth)) begin
			stk_we = 1'b0;
		end
		stk_ra = sp_q - SW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
			width_q <= 4'd9;
			mask_q <= 12'h1ff;
			next_q <= 13'd258;
			prev_q <= '0;
			prev_valid_q <= 1'b0;
			first_q <= '0;
			root_q <= 4'd8;
			given_q <= '0;
			end_q <= ST_PIXEL;
			fin_q <= 1'b0;
			sp_q <= '0;
			fill_q <= '0;
			walk_q <= '0;
			code_q <= '0;
			in_code_q <= '0;
		end else begin
			if (cmd.init) begin
				root_q <= root_c;
				buf_q <= '0;
				cnt_q <= '0;
				width_q <= root_c + 4'd1;
				mask_q <= 12'((13'd1 << (root_c + 4'd1)) - 13'd1);
				next_q <= (13'd1 << root_c) + 13'd2;
				prev_valid_q <= 1'b0;
				prev_q <= '0;
				first_q <= '0;
				given_q <= '0;
				end_q <= ST_PIXEL;
				fin_q <= 1'b0;
				sp_q <= '0;
				fill_q <= '0;
			end
			if (cmd.fill_step) begin
				fill_q <= fill_q + 13'd1;
			end
			if (cmd.take_byte) begin
				buf_q <= buf_q | (32'(item.data_byte) << cnt_q);
				cnt_q <= cnt_q + 6'd8;
				fin_q <= item.last_byte;
			end
			if (cmd.set_end) begin
				end_q <= cmd.end_code;
			end
			if (cmd.read_code) begin
				buf_q <= buf_q >> width_q;
				cnt_q <= cnt_q - 6'(width_q);
				code_q <= code_c;
				in_code_q <= code_c;
				walk_q <= 13'(code_c);
			end
			if (cmd.restart) begin
				width_q <= root_q + 4'd1;
				mask_q <= 12'((13'd1 << (root_q + 4'd1)) - 13'd1);
				next_q <= clear_c + 13'd2;
				prev_valid_q <= 1'b0;
				prev_q <= '0;
			end
			if (cmd.first_code) begin
				if (sp_q != SW'(StackDepth)) sp_q <= sp_q + SW'(1);
				prev_q <= code_q;
				prev_valid_q <= 1'b1;
				first_q <= code_q[7:0];
			end
			if (cmd.kwkwk) begin
				if (sp_q != SW'(StackDepth)) sp_q <= sp_q + SW'(1);
				walk_q <= 13'(prev_q);
			end
			if (cmd.walk_push) begin
				if (sp_q != SW'(StackDepth)) sp_q <= sp_q + SW'(1);
				walk_q <= 13'(pre_rd);
			end
			if (cmd.add_entry) begin
				first_q <= first_c;
				if (next_q < 13'(TableSize)) begin
					if (sp_q != SW'(StackDepth)) sp_q <= sp_q + SW'(1);
					next_q <= next_inc;
					if ((next_inc[11:0] & mask_q) == 12'd0 && next_inc < 13'(TableSize)) begin
						width_q <= width_q + 4'd1;
						mask_q <= mask_q + next_inc[11:0];
					end
					prev_q <= in_code_q;
				end
			end
			if (cmd.clear_stack) begin
				sp_q <= '0;
			end
			if (cmd.pop) begin
				sp_q <= sp_q - SW'(1);
				given_q <= given_q + PixelCountBits'(1);
			end
		end
	end

	always_comb begin
		stat.fill_done = (fill_q == 13'(TableSize));
		stat.byte_ok = (end_q == ST_PIXEL) && !fin_q && (cnt_q <= 6'd24);
		stat.bits_short = (cnt_q < 6'(width_q));
		stat.input_done = fin_q;
		stat.end_state = end_q;
		stat.frame_done = (given_q >= frame_pixels);
		stat.stack_empty = (sp_q == '0);
		stat.is_end_code = (13'(code_q) == clear_c + 13'd1);
		stat.is_bad = (13'(code_q) > next_q);
		stat.is_clear = (13'(code_q) == clear_c);
		stat.prev_valid = prev_valid_q;
		stat.first_bad = (13'(code_q) >= clear_c);
		stat.is_next = (13'(code_q) == next_q);
		stat.walk_more = (walk_q > clear_c) && (walk_q < 13'(TableSize));
		stat.table_full = (next_q >= 13'(TableSize));
		stat.pixel = stk_rd;
	end
endmodule

// ===== hw/rtl/gld_control.sv =====
// Controller state machine of the GIF LZW decoder: handshake, code decode
// sequence and result register. Uses gld_pkg.
module gld_control (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gld_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output gld_pkg::out_item_t out_item,
	output gld_pkg::dp_cmd_t cmd,
	input gld_pkg::dp_stat_t stat
);
	import gld_pkg::*;

	localparam logic [3:0] S_FILL = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CODE = 4'd2;
	localparam logic [3:0] S_READ = 4'd3;
	localparam logic [3:0] S_CLASS = 4'd4;
	localparam logic [3:0] S_WRD = 4'd5;
	localparam logic [3:0] S_WALK = 4'd6;
	localparam logic [3:0] S_ROOT = 4'd7;
	localparam logic [3:0] S_ADD = 4'd8;
	localparam logic [3:0] S_POPRD = 4'd9;
	localparam logic [3:0] S_POP = 4'd10;

	logic [3:0] state_q, state_d;
	logic ov_q;
	out_item_t oi_q;
	logic emit;
	out_item_t emit_item;
	logic accept;

	assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign out_valid = ov_q;
	assign out_item = oi_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		emit = 1'b0;
		emit_item = '{status: ST_PIXEL, pixel_index: 8'd0};
		case (state_q)
			S_FILL: begin
				if (stat.fill_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.fill_step = 1'b1;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (in_item.mode)
						MODE_START: begin
							cmd.init = 1'b1;
							emit = 1'b1;
							emit_item.status = ST_STARTED;
							state_d = S_FILL;
						end
						MODE_BYTE: begin
							emit = 1'b1;
							if (stat.byte_ok) begin
								cmd.take_byte = 1'b1;
								emit_item.status = ST_TAKEN;
							end else begin
								emit_item.status = ST_REFUSED;
							end
						end
						MODE_PIXEL: begin
							if (stat.end_state != ST_PIXEL) begin
								emit = 1'b1;
								emit_item.status = stat.end_state;
							end else if (stat.frame_done) begin
								emit = 1'b1;
								emit_item.status = ST_DONE;
								cmd.set_end = 1'b1;
								cmd.end_code = ST_DONE;
							end else if (stat.stack_empty) begin
								state_d = S_CODE;
							end else begin
								state_d = S_POPRD;
							end
						end
						default: ;
					endcase
				end
			end
			S_CODE: begin
				if (stat.bits_short) begin
					emit = 1'b1;
					state_d = S_IDLE;
					if (stat.input_done) begin
						emit_item.status = ST_EXHAUSTED;
						cmd.set_end = 1'b1;
						cmd.end_code = ST_EXHAUSTED;
					end else begin
						emit_item.status = ST_NEED;
					end
				end else begin
					cmd.read_code = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: state_d = S_CLASS;
			S_CLASS: begin
				if (stat.is_end_code || stat.is_bad) begin
					emit = 1'b1;
					state_d = S_IDLE;
					emit_item.status = stat.is_end_code ? ST_ENDCODE : ST_BAD;
					cmd.set_end = 1'b1;
					cmd.end_code = emit_item.status;
				end else if (stat.is_clear) begin
					cmd.restart = 1'b1;
					state_d = S_CODE;
				end else if (!stat.prev_valid) begin
					if (stat.first_bad) begin
						emit = 1'b1;
						state_d = S_IDLE;
						emit_item.status = ST_BAD;
						cmd.set_end = 1'b1;
						cmd.end_code = ST_BAD;
					end else begin
						cmd.first_code = 1'b1;
						state_d = S_POPRD;
					end
				end else if (stat.is_next) begin
					cmd.kwkwk = 1'b1;
					state_d = S_WRD;
				end else begin
					state_d = S_WRD;
				end
			end
			S_WRD: state_d = S_WALK;
			S_WALK: begin
				if (stat.walk_more) begin
					cmd.walk_push = 1'b1;
					state_d = S_WRD;
				end else begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				if (stat.table_full) begin
					cmd.clear_stack = 1'b1;
					cmd.set_end = 1'b1;
					cmd.end_code = ST_FULL;
					emit = 1'b1;
					emit_item.status = ST_FULL;
					state_d = S_IDLE;
				end else begin
					cmd.add_entry = 1'b1;
					state_d = S_ROOT;
				end
			end
			S_ROOT: state_d = S_POPRD;
			S_POPRD: state_d = S_POP;
			S_POP: begin
				emit = 1'b1;
				cmd.pop = 1'b1;
				emit_item.status = ST_PIXEL;
				emit_item.pixel_index = stat.pixel;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oi_q <= emit_item;
		end
	end
endmodule

// ===== hw/rtl/gld_checker.sv =====
// Port-level checker for the GIF LZW decoder, bound to the top level.
// Uses gld_pkg.
module gld_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input gld_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_stall,
	input gld_pkg::out_item_t out_item
);
	import gld_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");
	a_pix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_PIXEL |-> out_item.pixel_index == 8'd0)
		else $error("pixel index set on status");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= ST_STARTED)
		else $error("status out of range");
	a_start_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.mode == MODE_START |=> in_stall)
		else $error("item taken during table load");
endmodule

bind gif_lzw_decoder_top gld_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
	.out_item(out_item));
